@@ sv/post_pkg.sv @@
// Shared types, constants and tables for the phase offset sweep tuner.
package post_pkg;

  localparam int NUM_BINS    = 5;
  localparam int NUM_OFFSETS = 5;

  localparam int POS_W   = 3;
  localparam int SUM_W   = 18;
  localparam int SQ_W    = 2 * SUM_W;
  localparam int ACC_W   = 64;
  localparam int SCORE_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int RES_SLOTS = 3;
  localparam int RES_IDX_W = $clog2(RES_SLOTS);
  localparam int RES_CNT_W = $clog2(RES_SLOTS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_ABORT  = 2'd2;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PROGRESS  = 3'd1;
  localparam logic [2:0] EV_BIN_DONE  = 3'd2;
  localparam logic [2:0] EV_SWEEP_END = 3'd3;
  localparam logic [2:0] EV_ABORTED   = 3'd4;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_ABORTED = 2'd3;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_START,
    OP_ABORT,
    OP_IGNORE
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES,
    CFG_PERIOD,
    CFG_SPEED,
    CFG_CURRENT
  } cfg_idx_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [15:0] phase_u;
    logic signed [15:0] phase_v;
    logic signed [15:0] phase_w;
    logic        [15:0] motor_speed;
    logic        [9:0]  current_magnitude;
    logic        [7:0]  user_duty;
    logic               user_weakening;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  bin_index;
    logic [9:0]  offset_us;
    logic [31:0] score_low;
    logic [7:0]  duty_out;
    logic        weakening_out;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] samples_per_candidate;
    logic [7:0]  progress_period;
    logic [15:0] speed_limit;
    logic [9:0]  current_limit;
  } cfg_t;

  // Front stage contents: classified item with the phase sum already formed.
  typedef struct packed {
    op_t                     op;
    logic signed [SUM_W-1:0] phase_sum;
    logic        [15:0]      motor_speed;
    logic        [9:0]       current_magnitude;
    logic        [7:0]       user_duty;
    logic                    user_weakening;
  } stage_t;

  // Queue entry handed to the back end.
  typedef struct packed {
    op_t              op;
    logic [SQ_W-1:0]  score_inc;
    logic [15:0]      motor_speed;
    logic [9:0]       current_magnitude;
    logic [7:0]       user_duty;
    logic             user_weakening;
  } qentry_t;

  // Duty for each bin, 255 * percent / 100 worked out for each table entry.
  function automatic logic [7:0] bin_duty(input logic [POS_W-1:0] idx);
    logic [7:0] d;
    case (idx)
      3'd0:    d = 8'd63;
      3'd1:    d = 8'd114;
      3'd2:    d = 8'd165;
      3'd3:    d = 8'd204;
      default: d = 8'd229;
    endcase
    return d;
  endfunction

  function automatic logic [9:0] offset_us(input logic [POS_W-1:0] idx);
    logic [9:0] o;
    case (idx)
      3'd0:    o = 10'd200;
      3'd1:    o = 10'd400;
      3'd2:    o = 10'd600;
      3'd3:    o = 10'd800;
      default: o = 10'd1000;
    endcase
    return o;
  endfunction

endpackage

@@ sv/post_front.sv @@
// Front end: accepts items, classifies them and squares the phase sum.
module post_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  post_pkg::in_item_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output post_pkg::qentry_t  push_data
);

  logic                                  s1_valid_r;
  logic                                  s1_valid_nxt;
  post_pkg::stage_t                      s1_r;
  post_pkg::stage_t                      s1_nxt;
  logic                                  in_take;
  post_pkg::op_t                         op_cls;
  logic signed [2*post_pkg::SUM_W-1:0]   sq_full;

  assign in_stall = s1_valid_r && !push_ready;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    case (in_data.kind)
      post_pkg::KIND_SAMPLE: op_cls = post_pkg::OP_SAMPLE;
      post_pkg::KIND_START:  op_cls = post_pkg::OP_START;
      post_pkg::KIND_ABORT:  op_cls = post_pkg::OP_ABORT;
      default:               op_cls = post_pkg::OP_IGNORE;
    endcase
  end

  always_comb begin
    s1_nxt.op                = op_cls;
    s1_nxt.phase_sum         = post_pkg::SUM_W'(in_data.phase_u)
                             + post_pkg::SUM_W'(in_data.phase_v)
                             + post_pkg::SUM_W'(in_data.phase_w);
    s1_nxt.motor_speed       = in_data.motor_speed;
    s1_nxt.current_magnitude = in_data.current_magnitude;
    s1_nxt.user_duty         = in_data.user_duty;
    s1_nxt.user_weakening    = in_data.user_weakening;
  end

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= s1_nxt;
    end
  end

  // The square is non-negative, so its bit pattern serves as an unsigned increment.
  assign sq_full = s1_r.phase_sum * s1_r.phase_sum;

  assign push_valid                  = s1_valid_r;
  assign push_data.op                = s1_r.op;
  assign push_data.score_inc         = post_pkg::SQ_W'(sq_full);
  assign push_data.motor_speed       = s1_r.motor_speed;
  assign push_data.current_magnitude = s1_r.current_magnitude;
  assign push_data.user_duty         = s1_r.user_duty;
  assign push_data.user_weakening    = s1_r.user_weakening;

endmodule

@@ sv/post_queue.sv @@
// Short queue that decouples the front end from the back end.
module post_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  post_pkg::qentry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output post_pkg::qentry_t pop_data
);

  post_pkg::qentry_t               mem_r [post_pkg::QUEUE_DEPTH];
  logic [post_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [post_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [post_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [post_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [post_pkg::QCNT_W-1:0]     count_r;
  logic [post_pkg::QCNT_W-1:0]     count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = count_r != post_pkg::QCNT_W'(post_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/post_back.sv @@
// Back end: sweep state, candidate scoring, duty clamp and result sequencing.
module post_back (
  input  logic                clk,
  input  logic                rst_n,
  input  post_pkg::cfg_t      cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  post_pkg::qentry_t   pop_data,
  output logic                out_valid,
  input  logic                out_stall,
  output post_pkg::out_item_t out_data
);

  // Sweep state.
  logic                              running_r, running_nxt;
  logic [post_pkg::POS_W-1:0]        bin_r, bin_nxt;
  logic [post_pkg::POS_W-1:0]        off_r, off_nxt;
  logic [15:0]                       rem_r, rem_nxt;
  logic [post_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [post_pkg::SCORE_W-1:0]      best_r, best_nxt;
  logic [9:0]                        best_off_r, best_off_nxt;
  logic [7:0]                        pc_r, pc_nxt;
  logic [7:0]                        sduty_r, sduty_nxt;
  logic                              sweak_r, sweak_nxt;
  logic [7:0]                        duty_r, duty_nxt;
  logic                              weak_r, weak_nxt;
  logic [1:0]                        status_r, status_nxt;

  // Result sequencing.
  post_pkg::out_item_t               res_r [post_pkg::RES_SLOTS];
  post_pkg::out_item_t               res_new [post_pkg::RES_SLOTS];
  logic [post_pkg::RES_CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic [post_pkg::RES_IDX_W-1:0]    res_head_r, res_head_nxt;
  logic [post_pkg::RES_CNT_W-1:0]    e_cnt;
  logic                              out_valid_r, out_valid_nxt;
  post_pkg::out_item_t               out_data_r;
  logic                              move;
  logic                              take;

  // Per-item working values.
  logic [post_pkg::ACC_W-1:0]        acc_sum;
  logic [15:0]                       rem_dec;
  logic [7:0]                        duty_a;
  logic [7:0]                        duty_b;
  logic [7:0]                        pc_inc;
  logic                              improve;
  logic [9:0]                        best_off_cand;
  logic                              last_off;
  logic                              last_bin;
  logic                              ev_start, ev_abort, ev_prog, ev_bin, ev_end;

  assign move      = (res_cnt_r != '0) && (!out_valid_r || !out_stall);
  assign pop_ready = (res_cnt_r == '0) || ((res_cnt_r == post_pkg::RES_CNT_W'(1)) && move);
  assign take      = pop_valid && pop_ready;

  always_comb begin
    running_nxt  = running_r;
    bin_nxt      = bin_r;
    off_nxt      = off_r;
    rem_nxt      = rem_r;
    acc_nxt      = acc_r;
    best_nxt     = best_r;
    best_off_nxt = best_off_r;
    pc_nxt       = pc_r;
    sduty_nxt    = sduty_r;
    sweak_nxt    = sweak_r;
    duty_nxt     = duty_r;
    weak_nxt     = weak_r;
    status_nxt   = status_r;
    ev_start     = 1'b0;
    ev_abort     = 1'b0;
    ev_prog      = 1'b0;
    ev_bin       = 1'b0;
    ev_end       = 1'b0;

    acc_sum  = acc_r + post_pkg::ACC_W'(pop_data.score_inc);
    rem_dec  = (rem_r != 16'd0) ? rem_r - 16'd1 : rem_r;
    duty_a   = ((pop_data.motor_speed > cfg.speed_limit) && (duty_r > 8'd5)) ?
               duty_r - 8'd5 : duty_r;
    duty_b   = ((pop_data.current_magnitude > cfg.current_limit) && (duty_a != 8'd0)) ?
               duty_a - 8'd1 : duty_a;
    pc_inc   = pc_r + 8'd1;
    improve  = acc_sum < {{(post_pkg::ACC_W-post_pkg::SCORE_W){1'b0}}, best_r};
    best_off_cand = improve ? post_pkg::offset_us(off_r) : best_off_r;
    last_off = off_r == post_pkg::POS_W'(post_pkg::NUM_OFFSETS - 1);
    last_bin = bin_r == post_pkg::POS_W'(post_pkg::NUM_BINS - 1);

    case (pop_data.op)
      post_pkg::OP_START: begin
        if (!running_r) begin
          running_nxt  = 1'b1;
          bin_nxt      = '0;
          off_nxt      = '0;
          rem_nxt      = cfg.samples_per_candidate;
          acc_nxt      = '0;
          best_nxt     = '1;
          best_off_nxt = post_pkg::offset_us('0);
          pc_nxt       = '0;
          sduty_nxt    = pop_data.user_duty;
          sweak_nxt    = pop_data.user_weakening;
          weak_nxt     = 1'b0;
          duty_nxt     = post_pkg::bin_duty('0);
          status_nxt   = post_pkg::ST_RUNNING;
          ev_start     = 1'b1;
        end
      end
      post_pkg::OP_ABORT: begin
        if (running_r) begin
          running_nxt = 1'b0;
          duty_nxt    = sduty_r;
          weak_nxt    = sweak_r;
          status_nxt  = post_pkg::ST_ABORTED;
          ev_abort    = 1'b1;
        end
      end
      post_pkg::OP_SAMPLE: begin
        if (running_r) begin
          acc_nxt  = acc_sum;
          rem_nxt  = rem_dec;
          duty_nxt = duty_b;
          pc_nxt   = pc_inc;
          if (pc_inc >= cfg.progress_period) begin
            pc_nxt  = '0;
            ev_prog = 1'b1;
          end
          if (rem_dec == 16'd0) begin
            if (improve) begin
              best_nxt = acc_sum[post_pkg::SCORE_W-1:0];
            end
            best_off_nxt = best_off_cand;
            off_nxt      = off_r + 1'b1;
            if (last_off) begin
              ev_bin = 1'b1;
              if (last_bin) begin
                // The sweep ends: the position stays on the last bin.
                ev_end      = 1'b1;
                duty_nxt    = sduty_r;
                weak_nxt    = sweak_r;
                running_nxt = 1'b0;
                status_nxt  = post_pkg::ST_DONE;
              end else begin
                bin_nxt      = bin_r + 1'b1;
                off_nxt      = '0;
                best_nxt     = '1;
                best_off_nxt = post_pkg::offset_us('0);
                duty_nxt     = post_pkg::bin_duty(bin_r + 1'b1);
              end
            end
            if (!(last_off && last_bin)) begin
              rem_nxt = cfg.samples_per_candidate;
              acc_nxt = '0;
              pc_nxt  = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Lay the results of the item out in order; every slot shares the final drive state.
  always_comb begin
    for (int i = 0; i < post_pkg::RES_SLOTS; i++) begin
      res_new[i].event_res     = post_pkg::EV_NONE;
      res_new[i].bin_index     = bin_nxt;
      res_new[i].offset_us     = '0;
      res_new[i].score_low     = '0;
      res_new[i].duty_out      = duty_nxt;
      res_new[i].weakening_out = weak_nxt;
      res_new[i].status        = status_nxt;
      res_new[i].last          = 1'b0;
    end
    e_cnt = '0;
    if (ev_start) begin
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].event_res = post_pkg::EV_PROGRESS;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].bin_index = '0;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].offset_us = post_pkg::offset_us('0);
      e_cnt = e_cnt + 1'b1;
    end
    if (ev_abort) begin
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].event_res = post_pkg::EV_ABORTED;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].bin_index = bin_r;
      e_cnt = e_cnt + 1'b1;
    end
    if (ev_prog) begin
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].event_res = post_pkg::EV_PROGRESS;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].bin_index = bin_r;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].offset_us = post_pkg::offset_us(off_r);
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].score_low = acc_sum[post_pkg::SCORE_W-1:0];
      e_cnt = e_cnt + 1'b1;
    end
    if (ev_bin) begin
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].event_res = post_pkg::EV_BIN_DONE;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].bin_index = bin_r;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].offset_us = best_off_cand;
      e_cnt = e_cnt + 1'b1;
    end
    if (ev_end) begin
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].event_res = post_pkg::EV_SWEEP_END;
      res_new[e_cnt[post_pkg::RES_IDX_W-1:0]].bin_index = bin_r;
      e_cnt = e_cnt + 1'b1;
    end
    if (e_cnt == '0) begin
      e_cnt = post_pkg::RES_CNT_W'(1);
    end
    res_new[post_pkg::RES_IDX_W'(e_cnt - 1'b1)].last = 1'b1;
  end

  always_comb begin
    res_cnt_nxt   = res_cnt_r;
    res_head_nxt  = res_head_r;
    out_valid_nxt = out_valid_r;
    if (move) begin
      res_cnt_nxt   = res_cnt_r - 1'b1;
      res_head_nxt  = res_head_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      res_cnt_nxt  = e_cnt;
      res_head_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      bin_r       <= '0;
      off_r       <= '0;
      rem_r       <= '0;
      acc_r       <= '0;
      best_r      <= '1;
      best_off_r  <= post_pkg::offset_us('0);
      pc_r        <= '0;
      sduty_r     <= '0;
      sweak_r     <= 1'b0;
      duty_r      <= '0;
      weak_r      <= 1'b0;
      status_r    <= post_pkg::ST_IDLE;
      res_cnt_r   <= '0;
      res_head_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        running_r  <= running_nxt;
        bin_r      <= bin_nxt;
        off_r      <= off_nxt;
        rem_r      <= rem_nxt;
        acc_r      <= acc_nxt;
        best_r     <= best_nxt;
        best_off_r <= best_off_nxt;
        pc_r       <= pc_nxt;
        sduty_r    <= sduty_nxt;
        sweak_r    <= sweak_nxt;
        duty_r     <= duty_nxt;
        weak_r     <= weak_nxt;
        status_r   <= status_nxt;
      end
      res_cnt_r   <= res_cnt_nxt;
      res_head_r  <= res_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= res_r[res_head_r];
    end
    if (take) begin
      for (int i = 0; i < post_pkg::RES_SLOTS; i++) begin
        res_r[i] <= res_new[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every item leaves at least one result behind it.
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> res_cnt_r != '0)
    else $error("item taken without any result queued");

  // A result that is not the last of its item always has a successor waiting.
  a_non_last_has_successor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> res_cnt_r != '0)
    else $error("non-final result with nothing behind it");

  a_running_status: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == (status_r == post_pkg::ST_RUNNING))
    else $error("running flag and status disagree");

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (bin_r < post_pkg::POS_W'(post_pkg::NUM_BINS)) &&
                  (off_r < post_pkg::POS_W'(post_pkg::NUM_OFFSETS)))
    else $error("sweep position out of range while running");

endmodule

@@ sv/phase_offset_sweep_tuner.sv @@
// Top level of the phase offset sweep tuner: configuration registers and the two halves.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  post_pkg::in_item_t
//   out_     output     out_valid/out_stall post_pkg::out_item_t
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item passes one front register and the queue, then the back end moves its results
// (one to three) one at a time from its result slots through the output register, where
// each result becomes valid and can transfer.
// A new item is taken every cycle while each brings one result and out_stall is low;
// an item with more results holds the back end until its last result moves on.
// Reset is synchronous and active low and clears all control state; there is no clearing pass.
// Output stalls fill the back end's result slots, then the four-entry queue and the front
// register, after which in_stall rises.
module phase_offset_sweep_tuner (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  post_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output post_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [post_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [post_pkg::CFG_DATA_W-1:0]      cfg_data
);

  post_pkg::cfg_t    cfg_r;
  post_pkg::cfg_t    cfg_nxt;
  logic              push_valid;
  logic              push_ready;
  post_pkg::qentry_t push_data;
  logic              pop_valid;
  logic              pop_ready;
  post_pkg::qentry_t pop_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (post_pkg::cfg_idx_t'(cfg_index))
        post_pkg::CFG_SAMPLES: cfg_nxt.samples_per_candidate = cfg_data;
        post_pkg::CFG_PERIOD:  cfg_nxt.progress_period       = cfg_data[7:0];
        post_pkg::CFG_SPEED:   cfg_nxt.speed_limit           = cfg_data;
        post_pkg::CFG_CURRENT: cfg_nxt.current_limit         = cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_candidate <= 16'd256;
      cfg_r.progress_period       <= 8'd8;
      cfg_r.speed_limit           <= 16'd200;
      cfg_r.current_limit         <= 10'd24;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  post_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  post_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  post_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/sweep_tuner_checker.sv @@
// Result checker for the phase offset sweep tuner: tracks the sweep and compares every result.
`timescale 1ns / 100ps
module sweep_tuner_checker
  import post_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    events_in_flight
);

  cfg_t        settings;
  logic        sweep_active;
  logic [2:0]  bin_pos;
  logic [2:0]  offset_pos;
  logic [15:0] cand_due;
  logic [63:0] score_acc;
  logic [31:0] cand_best;
  logic [9:0]  best_offset;
  logic [7:0]  progress_cnt;
  logic [7:0]  user_duty_saved;
  logic        user_weak_saved;
  logic [7:0]  duty_drive;
  logic        weak_drive;
  logic [1:0]  sweep_status;

  out_item_t   sweep_events_q[$];
  out_item_t   step_events[3];
  int          step_count;
  out_item_t   oldest_event;

  function automatic logic [9:0] offset_for(input logic [2:0] pos);
    return (pos < 3'd4) ? 10'(200 * (pos + 1)) : 10'd1000;
  endfunction

  function automatic logic [7:0] duty_for(input logic [2:0] bin);
    int pct;
    case (bin)
      3'd0:    pct = 25;
      3'd1:    pct = 45;
      3'd2:    pct = 65;
      3'd3:    pct = 80;
      default: pct = 90;
    endcase
    return 8'((255 * pct) / 100);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: sweep result mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, should be %0d", field, got, want));
  endtask

  task automatic add_event(input logic [2:0] ev, input logic [2:0] bin, input logic [9:0] offs,
                           input logic [31:0] score);
    if (step_count < 3) begin
      step_events[step_count] = '0;
      step_events[step_count].event_res = ev;
      step_events[step_count].bin_index = bin;
      step_events[step_count].offset_us = offs;
      step_events[step_count].score_low = score;
      step_count++;
    end
  endtask

  // A candidate is finished: keep it if it beat the bin's best, then move on.
  task automatic close_candidate();
    logic sweep_over;
    sweep_over = 1'b0;
    if (score_acc < {32'd0, cand_best}) begin
      cand_best   = score_acc[31:0];
      best_offset = offset_for(offset_pos);
    end
    offset_pos++;
    if (offset_pos >= NUM_OFFSETS) begin
      add_event(EV_BIN_DONE, bin_pos, best_offset, '0);
      if (bin_pos + 1 >= NUM_BINS) begin
        // The bin position stays on the last bin once the sweep has ended.
        add_event(EV_SWEEP_END, bin_pos, '0, '0);
        duty_drive   = user_duty_saved;
        weak_drive   = user_weak_saved;
        sweep_active = 1'b0;
        sweep_status = ST_DONE;
        sweep_over   = 1'b1;
      end else begin
        bin_pos++;
        offset_pos  = '0;
        cand_best   = '1;
        best_offset = offset_for(3'd0);
        duty_drive  = duty_for(bin_pos);
      end
    end
    if (!sweep_over) begin
      cand_due     = settings.samples_per_candidate;
      score_acc    = '0;
      progress_cnt = '0;
    end
  endtask

  task automatic advance_sweep(input in_item_t it);
    longint phase_sum;
    longint square;
    op_t    op;
    op = op_t'(it.kind);
    step_count = 0;
    if (op == OP_START && !sweep_active) begin
      sweep_active    = 1'b1;
      bin_pos         = '0;
      offset_pos      = '0;
      cand_due        = settings.samples_per_candidate;
      score_acc       = '0;
      cand_best       = '1;
      best_offset     = offset_for(3'd0);
      progress_cnt    = '0;
      user_duty_saved = it.user_duty;
      user_weak_saved = it.user_weakening;
      weak_drive      = 1'b0;
      duty_drive      = duty_for(3'd0);
      sweep_status    = ST_RUNNING;
      add_event(EV_PROGRESS, 3'd0, offset_for(3'd0), '0);
    end else if (op == OP_ABORT && sweep_active) begin
      sweep_active = 1'b0;
      duty_drive   = user_duty_saved;
      weak_drive   = user_weak_saved;
      sweep_status = ST_ABORTED;
      add_event(EV_ABORTED, bin_pos, '0, '0);
    end else if (op == OP_SAMPLE && sweep_active) begin
      phase_sum = longint'($signed(it.phase_u)) + longint'($signed(it.phase_v))
                + longint'($signed(it.phase_w));
      square    = phase_sum * phase_sum;
      score_acc = score_acc + 64'(square);
      if (cand_due != 0) cand_due--;
      if (it.motor_speed > settings.speed_limit && duty_drive > 8'd5) duty_drive -= 8'd5;
      if (it.current_magnitude > settings.current_limit && duty_drive > 8'd0) duty_drive--;
      progress_cnt++;
      if (progress_cnt >= settings.progress_period) begin
        progress_cnt = '0;
        add_event(EV_PROGRESS, bin_pos, offset_for(offset_pos), score_acc[31:0]);
      end
      if (cand_due == 0) close_candidate();
    end
    if (step_count == 0) add_event(EV_NONE, bin_pos, '0, '0);
    for (int k = 0; k < step_count; k++) begin
      step_events[k].duty_out      = duty_drive;
      step_events[k].weakening_out = weak_drive;
      step_events[k].status        = sweep_status;
      step_events[k].last          = (k == step_count - 1);
      sweep_events_q.push_back(step_events[k]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.samples_per_candidate = 16'd256;
      settings.progress_period       = 8'd8;
      settings.speed_limit           = 16'd200;
      settings.current_limit         = 10'd24;
      sweep_active    = 1'b0;
      bin_pos         = '0;
      offset_pos      = '0;
      cand_due        = '0;
      score_acc       = '0;
      cand_best       = '1;
      best_offset     = 10'd200;
      progress_cnt    = '0;
      user_duty_saved = '0;
      user_weak_saved = 1'b0;
      duty_drive      = '0;
      weak_drive      = 1'b0;
      sweep_status    = ST_IDLE;
      sweep_events_q.delete();
    end else begin
      // Results leave in the order their items were taken, so the oldest is compared first.
      if (out_valid && !out_stall) begin
        if (sweep_events_q.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing outstanding", out_data));
        end else begin
          oldest_event = sweep_events_q.pop_front();
          check_field("event_res", out_data.event_res, oldest_event.event_res);
          check_field("bin_index", out_data.bin_index, oldest_event.bin_index);
          check_field("offset_us", out_data.offset_us, oldest_event.offset_us);
          check_field("score_low", out_data.score_low, oldest_event.score_low);
          check_field("duty_out", out_data.duty_out, oldest_event.duty_out);
          check_field("weakening_out", out_data.weakening_out, oldest_event.weakening_out);
          check_field("status", out_data.status, oldest_event.status);
          check_field("last", out_data.last, oldest_event.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SAMPLES: settings.samples_per_candidate = cfg_data;
          CFG_PERIOD:  settings.progress_period       = cfg_data[7:0];
          CFG_SPEED:   settings.speed_limit           = cfg_data;
          CFG_CURRENT: settings.current_limit         = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_sweep(in_data);
    end
    events_in_flight <= sweep_events_q.size();
  end

endmodule

@@ tb/sv/tb_phase_offset_sweep_tuner.sv @@
// Testbench top for the phase offset sweep tuner: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps
module tb_phase_offset_sweep_tuner;
  import post_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_SAMPLES;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int mismatch_count;
  int events_in_flight;

  // Rough view of the sweep, used only to keep most items inside a running sweep.
  int sweep_remaining = 0;
  int sweep_len       = NUM_BINS * NUM_OFFSETS * 256;
  int speed_setting   = 200;
  int current_setting = 24;

  phase_offset_sweep_tuner u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sweep_tuner_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .events_in_flight (events_in_flight)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Valid stays high after a transfer; the next item either follows at once or idles first.
  task automatic push_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input int samples, input int period, input int speed,
                                input int current);
    write_register(CFG_SAMPLES, 16'(samples));
    write_register(CFG_PERIOD, 16'(period));
    write_register(CFG_SPEED, 16'(speed));
    write_register(CFG_CURRENT, 16'(current));
    cfg_valid       <= 1'b0;
    sweep_len       = NUM_BINS * NUM_OFFSETS * ((samples == 0) ? 1 : samples);
    speed_setting   = speed;
    current_setting = current;
  endtask

  // Holds off until every result of the items sent so far has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_in_flight != 0);
  endtask

  function automatic in_item_t make_item(input op_t op, input logic [15:0] u,
                                         input logic [15:0] v, input logic [15:0] w,
                                         input logic [15:0] speed, input logic [9:0] mag,
                                         input logic [7:0] duty, input logic weakening);
    in_item_t it;
    it.kind              = op;
    it.phase_u           = u;
    it.phase_v           = v;
    it.phase_w           = w;
    it.motor_speed       = speed;
    it.current_magnitude = mag;
    it.user_duty         = duty;
    it.user_weakening    = weakening;
    return it;
  endfunction

  function automatic logic [15:0] rand_current();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'($urandom);
      1:       v = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: v = 16'($urandom_range(0, 127)) - 16'd64;
    endcase
    return v;
  endfunction

  task automatic run_random(input int count);
    in_item_t it;
    int       counted;
    int       pick;
    counted = 0;
    while (counted < count) begin
      it.phase_u   = rand_current();
      it.phase_v   = rand_current();
      it.phase_w   = rand_current();
      // Speeds and magnitudes often sit right on the clamp thresholds.
      it.motor_speed = $urandom_range(0, 1) ? 16'($urandom)
                                            : 16'(speed_setting + $urandom_range(0, 4) - 2);
      it.current_magnitude = $urandom_range(0, 1) ? 10'($urandom)
                                                  : 10'(current_setting + $urandom_range(0, 4) - 2);
      it.user_duty      = 8'($urandom);
      it.user_weakening = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (sweep_remaining == 0) begin
        if (pick < 85) begin
          it.kind         = OP_START;
          sweep_remaining = sweep_len;
          counted++;
        end else if (pick < 90) begin
          it.kind = OP_SAMPLE;
        end else if (pick < 95) begin
          it.kind = OP_ABORT;
        end else begin
          it.kind = OP_IGNORE;
        end
      end else begin
        counted++;
        if (pick < 3) begin
          it.kind         = OP_ABORT;
          sweep_remaining = 0;
        end else if (pick < 6) begin
          it.kind = OP_START;
        end else if (pick < 9) begin
          it.kind = OP_IGNORE;
        end else begin
          it.kind = OP_SAMPLE;
          sweep_remaining--;
        end
      end
      push_item(it);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset settings: a progress report falls on the eighth sample.
    send_idle_pct  = 10;
    recv_stall_pct = 63;
    push_item(make_item(OP_IGNORE, '1, '1, '1, '1, '1, '1, 1'b1));
    push_item(make_item(OP_SAMPLE, '0, '0, '0, '0, '0, '0, 1'b0));
    push_item(make_item(OP_ABORT, '0, '0, '0, '0, '0, '0, 1'b0));
    push_item(make_item(OP_START, '0, '0, '0, '1, '1, 8'hFF, 1'b1));
    push_item(make_item(OP_START, '0, '0, '0, '0, '0, 8'h00, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'd201, 10'd25, '0, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd200, 10'd24, '0, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'd1, '1, '1, '0, 1'b0));
    push_item(make_item(OP_SAMPLE, '0, '0, '0, '0, '0, '0, 1'b0));
    push_item(make_item(OP_IGNORE, 16'd5, 16'd6, 16'd7, '1, '1, '1, 1'b1));
    push_item(make_item(OP_SAMPLE, 16'd100, -16'sd50, 16'd7, 16'd300, 10'd30, '0, 1'b0));
    push_item(make_item(OP_SAMPLE, '1, '1, '1, 16'd199, 10'd23, '0, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h5555, 16'hAAAA, 16'h1234, '1, '1, '0, 1'b0));
    push_item(make_item(OP_SAMPLE, -16'sd300, 16'd200, 16'd99, '1, '1, '0, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'd1, 16'd1, 16'd1, '1, '1, '0, 1'b0));
    push_item(make_item(OP_ABORT, '0, '0, '0, '0, '0, '0, 1'b0));
    push_item(make_item(OP_START, '0, '0, '0, '0, '0, 8'h5A, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'd3, 16'd3, 16'd3, '0, '0, '0, 1'b0));
    push_item(make_item(OP_ABORT, '0, '0, '0, '0, '0, '0, 1'b0));
    settle();

    // Every sample closes a candidate and reports, so the last one of a sweep gives three.
    write_settings(0, 0, 100, 1000);
    run_random(75);
    settle();

    send_idle_pct  = 63;
    recv_stall_pct = 10;
    write_settings(2, 3, 65535, 0);
    run_random(90);
    settle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_settings(1, 1, 0, 1023);
    run_random(55);
    settle();

    write_settings(65535, 255, 40000, 512);
    run_random(25);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ phase_offset_sweep_tuner.f @@
sv/post_pkg.sv
sv/post_front.sv
sv/post_queue.sv
sv/post_back.sv
sv/phase_offset_sweep_tuner.sv
tb/sv/sweep_tuner_checker.sv
tb/sv/tb_phase_offset_sweep_tuner.sv
